// ===== rtl/hkv_pkg.sv =====
// ----------------------------------------------------------------------------
// hkv_pkg
// shared types and constants of the hashed key-value table
// ----------------------------------------------------------------------------
package hkv_pkg;

   localparam logic [1:0] REQ_MATCH  = 2'd0;
   localparam logic [1:0] REQ_ENTER  = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_NONE   = 2'd3;

   localparam logic CSR_KEY_BYTES   = 1'b0;
   localparam logic CSR_BUCKET_BITS = 1'b1;

   localparam logic [3:0] KEY_BYTES_RESET   = 4'd4;
   localparam logic [3:0] BUCKET_BITS_RESET = 4'd10;

   localparam int BUCKET_IDX_BITS = 16;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] key;
      logic [31:0] value;
   } req_item_type;

   typedef struct packed {
      logic        found;
      logic [31:0] value_out;
      logic        status;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]                 req_type;
      logic [63:0]                key;
      logic [31:0]                value;
      logic [63:0]                key_mask;
      logic [BUCKET_IDX_BITS-1:0] bucket;
   } work_item_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL
   } back_state_type;

endpackage

// ===== rtl/hashed_key_value_table.sv =====
// ----------------------------------------------------------------------------
// hashed_key_value_table
// key-value table with hashed, set-associative buckets
//
// requests enter on req_push/req_full and carry a match, enter or remove
// of a key; each request gives exactly one response on rsp_empty/rsp_pop,
// in request order. csr_we/csr_index/csr_wdata set the key size and the
// bucket mask width; write them only while no request is in flight.
// the front hashes the key and picks the bucket in a two-stage pipeline,
// then a two-entry queue feeds the back, which reads the bucket row from
// ram and writes it back; the back takes no new request until that
// read-modify-write of the bucket rams is done. after reset the valid
// store is cleared one bucket a cycle until all BUCKETS buckets are
// cleared; req_full stays high meanwhile. a stalled response consumer
// fills the two-entry response queue, then the back stops, the request
// queue fills and req_full rises.
// ----------------------------------------------------------------------------
module hashed_key_value_table #(
   parameter int BUCKETS    = 1024,
   parameter int WAYS       = 4,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  hkv_pkg::req_item_type req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output hkv_pkg::rsp_item_type rsp_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [3:0]            csr_wdata
);
   import hkv_pkg::*;

   logic          wq_push, wq_full, wq_pop, wq_empty;
   work_item_type wq_in, wq_head;
   logic          rq_push, rq_full, clear_busy;
   rsp_item_type  rq_in;

   hkv_front #(.BUCKETS(BUCKETS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .hold      (clear_busy),
      .q_full    (wq_full),
      .q_push    (wq_push),
      .q_data    (wq_in)
   );

   hkv_queue #(.item_type(work_item_type), .DEPTH(2)) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (wq_push),
      .full      (wq_full),
      .push_data (wq_in),
      .pop       (wq_pop),
      .empty     (wq_empty),
      .head      (wq_head)
   );

   hkv_back #(.BUCKETS(BUCKETS), .WAYS(WAYS), .VALUE_BITS(VALUE_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (wq_empty),
      .q_pop      (wq_pop),
      .q_data     (wq_head),
      .rsp_full   (rq_full),
      .rsp_push   (rq_push),
      .rsp_item   (rq_in),
      .clear_busy (clear_busy)
   );

   hkv_queue #(.item_type(rsp_item_type), .DEPTH(2)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .full      (rq_full),
      .push_data (rq_in),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_data)
   );
endmodule

// ===== rtl/hkv_ram.sv =====
// ----------------------------------------------------------------------------
// hkv_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/hkv_queue.sv =====
// ----------------------------------------------------------------------------
// hkv_queue
// small first-in first-out queue of items
// ----------------------------------------------------------------------------
module hkv_queue #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  item_type push_data,
   input  logic     pop,
   output logic     empty,
   output item_type head
);
   localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full    = cnt_ff == CW'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wp_in = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (do_pop) begin
         rp_in = (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end
endmodule

// ===== rtl/hkv_front.sv =====
// ----------------------------------------------------------------------------
// hkv_front
// request intake: config registers, key hash and bucket selection
// ----------------------------------------------------------------------------
module hkv_front #(
   parameter int BUCKETS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  hkv_pkg::req_item_type req_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [3:0]            csr_wdata,
   input  logic                  hold,
   input  logic                  q_full,
   output logic                  q_push,
   output hkv_pkg::work_item_type q_data
);
   import hkv_pkg::*;

   logic [3:0]    key_bytes_ff, bucket_bits_ff;
   logic [3:0]    eff;
   logic [63:0]   km;
   logic [31:0]   h, bmask;
   logic          s1_v_ff, s2_v_ff, s1_ready, s2_ready, accept;
   work_item_type s1_ff, s1_in, s2_ff, s2_in;

   function automatic logic [15:0] reduce_hi(logic [15:0] r);
      for (int i = 15; i >= 8; i--) begin
         if (33'(r) >= (33'(BUCKETS) << i)) begin
            r = r - 16'(33'(BUCKETS) << i);
         end
      end
      return r;
   endfunction

   function automatic logic [15:0] reduce_lo(logic [15:0] r);
      for (int i = 7; i >= 0; i--) begin
         if (33'(r) >= (33'(BUCKETS) << i)) begin
            r = r - 16'(33'(BUCKETS) << i);
         end
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff   <= KEY_BYTES_RESET;
         bucket_bits_ff <= BUCKET_BITS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_BYTES:   key_bytes_ff   <= csr_wdata;
            CSR_BUCKET_BITS: bucket_bits_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // hash of the key under the current key size
   always_comb begin
      eff = (key_bytes_ff > 4'd8) ? 4'd8 : key_bytes_ff;
      km  = (eff >= 4'd8) ? '1 : (64'd1 << {eff[2:0], 3'b000}) - 64'd1;
      h   = '0;
      if (eff inside {4'd1, 4'd2, 4'd4}) begin
         h = km[31:0] & req_data.key[31:0];
      end else if (eff == 4'd8) begin
         h = req_data.key[31:0] + req_data.key[63:32];
      end else begin
         for (int i = 7; i >= 0; i--) begin
            if (4'(i) < eff) begin
               h = {h[27:0], h[31:28]} + {24'd0, req_data.key[8*i +: 8]};
            end
         end
      end
      bmask = (32'd1 << bucket_bits_ff) - 32'd1;
      s1_in.req_type = req_data.req_type;
      s1_in.key      = req_data.key;
      s1_in.value    = req_data.value;
      s1_in.key_mask = km;
      s1_in.bucket   = 16'(h & bmask);
   end

   always_comb begin
      s2_in        = s1_ff;
      s2_in.bucket = reduce_hi(s1_ff.bucket);
      q_data        = s2_ff;
      q_data.bucket = reduce_lo(s2_ff.bucket);
   end

   assign s2_ready = !s2_v_ff || !q_full;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign req_full = !s1_ready || hold;
   assign accept   = req_push && !req_full;
   assign q_push   = s2_v_ff && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_v_ff <= accept;
         end
         if (s2_ready) begin
            s2_v_ff <= s1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && accept) begin
         s1_ff <= s1_in;
      end
      if (s2_ready && s1_v_ff) begin
         s2_ff <= s2_in;
      end
   end
endmodule

// ===== rtl/hkv_back.sv =====
// ----------------------------------------------------------------------------
// hkv_back
// bucket read-modify-write engine and valid store clearing pass
// ----------------------------------------------------------------------------
module hkv_back #(
   parameter int BUCKETS    = 1024,
   parameter int WAYS       = 4,
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   output logic                   q_pop,
   input  hkv_pkg::work_item_type q_data,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output hkv_pkg::rsp_item_type  rsp_item,
   output logic                   clear_busy
);
   import hkv_pkg::*;

   localparam int AW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
   localparam int WW = WAYS > 1 ? $clog2(WAYS) : 1;

   back_state_type          state_ff, state_in;
   logic [AW-1:0]           clr_ff, clr_in;
   work_item_type           cur_ff;
   logic                    start;
   logic [AW-1:0]           waddr;
   logic                    vld_we, row_we;
   logic [WAYS-1:0]         vrow, vrow_new, vld_wdata;
   logic [WAYS*64-1:0]      krow, krow_new;
   logic [WAYS*VALUE_BITS-1:0] valrow, valrow_new;
   logic                    hit_any, free_any;
   logic [WW-1:0]           hit_idx, free_idx;
   logic [VALUE_BITS-1:0]   val;

   assign start = (state_ff == ST_IDLE) && !q_empty && !rsp_full;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(BUCKETS - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = ST_EVAL;
         ST_EVAL:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop      = 1'b0;
      rsp_push   = 1'b0;
      clear_busy = 1'b0;
      vld_we     = 1'b0;
      row_we     = 1'b0;
      clr_in     = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_busy = 1'b1;
            vld_we     = 1'b1;
            clr_in     = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            q_pop = start;
         end
         ST_EVAL: begin
            rsp_push = 1'b1;
            vld_we   = 1'b1;
            row_we   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cur_ff <= q_data;
      end
   end

   // compare all ways of the bucket and apply the request
   always_comb begin
      hit_any    = 1'b0;
      free_any   = 1'b0;
      hit_idx    = '0;
      free_idx   = '0;
      val        = VALUE_BITS'(cur_ff.value);
      for (int w = 0; w < WAYS; w++) begin
         if (vrow[w]) begin
            if (!hit_any && ((krow[w*64 +: 64] ^ cur_ff.key) & cur_ff.key_mask) == '0) begin
               hit_any = 1'b1;
               hit_idx = WW'(w);
            end
         end else if (!free_any) begin
            free_any = 1'b1;
            free_idx = WW'(w);
         end
      end
      vrow_new   = vrow;
      krow_new   = krow;
      valrow_new = valrow;
      rsp_item.found     = (cur_ff.req_type != REQ_NONE) && hit_any;
      rsp_item.value_out = '0;
      rsp_item.status    = 1'b0;
      case (cur_ff.req_type)
         REQ_MATCH: begin
            if (hit_any) begin
               rsp_item.value_out = 32'(valrow[hit_idx*VALUE_BITS +: VALUE_BITS]);
            end
         end
         REQ_ENTER: begin
            if (hit_any) begin
               valrow_new[hit_idx*VALUE_BITS +: VALUE_BITS] = val;
            end else if (free_any) begin
               vrow_new[free_idx]                            = 1'b1;
               krow_new[free_idx*64 +: 64]                   = cur_ff.key;
               valrow_new[free_idx*VALUE_BITS +: VALUE_BITS] = val;
            end else begin
               rsp_item.status = 1'b1;
            end
         end
         REQ_REMOVE: begin
            if (hit_any) begin
               vrow_new[hit_idx] = 1'b0;
            end
         end
         default: ;
      endcase
   end

   assign waddr     = (state_ff == ST_CLEAR) ? clr_ff : cur_ff.bucket[AW-1:0];
   assign vld_wdata = (state_ff == ST_CLEAR) ? '0 : vrow_new;

   hkv_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_vld_ram (
      .clock (clock),
      .we    (vld_we),
      .waddr (waddr),
      .wdata (vld_wdata),
      .re    (start),
      .raddr (q_data.bucket[AW-1:0]),
      .rdata (vrow)
   );

   hkv_ram #(.WIDTH(WAYS*64), .DEPTH(BUCKETS)) u_key_ram (
      .clock (clock),
      .we    (row_we),
      .waddr (waddr),
      .wdata (krow_new),
      .re    (start),
      .raddr (q_data.bucket[AW-1:0]),
      .rdata (krow)
   );

   hkv_ram #(.WIDTH(WAYS*VALUE_BITS), .DEPTH(BUCKETS)) u_val_ram (
      .clock (clock),
      .we    (row_we),
      .waddr (waddr),
      .wdata (valrow_new),
      .re    (start),
      .raddr (q_data.bucket[AW-1:0]),
      .rdata (valrow)
   );
endmodule

// ===== rtl/hkv_checker.sv =====
// ----------------------------------------------------------------------------
// hkv_checker
// port-level checks of the hashed key-value table
// ----------------------------------------------------------------------------
module hkv_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_full,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input hkv_pkg::rsp_item_type rsp_data
);
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response present right after reset");

   a_reset_full: assert property (@(posedge clock) reset |=> req_full)
      else $error("request taken during clearing pass");

   a_refused_not_found: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_data.status && rsp_data.found))
      else $error("refused enter reported as found");

   a_value_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.value_out != '0) |-> (rsp_data.found && !rsp_data.status))
      else $error("value returned without a hit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled response changed");
endmodule

bind hashed_key_value_table hkv_checker u_hkv_checker (.*);

// ===== tb/tb_hashed_key_value_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hashed_key_value_table
// self-checking bench for the hashed key-value table
//
// directed requests cover the request codes, key sizes, bucket mask widths,
// a full bucket and duplicate keys after a key size change; random phases
// follow under several register settings. every request is run through a
// local model of the bucket store and each response is compared in order.
// ----------------------------------------------------------------------------
module tb_hashed_key_value_table;
   import hkv_pkg::*;

   localparam int BUCKETS = 1024;
   localparam int WAYS    = 4;
   localparam int SLOTS   = BUCKETS * WAYS;

   typedef struct {
      logic [1:0]  req_type;
      logic [63:0] key;
      logic [31:0] value;
      bit          has_rsp;
      rsp_item_type rsp;
   } table_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_push = 1'b0;
   logic         req_full;
   req_item_type req_data = '0;
   logic         rsp_empty;
   logic         rsp_pop = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_we = 1'b0;
   logic         csr_index = 1'b0;
   logic [3:0]   csr_wdata = '0;

   bit          mdl_valid [SLOTS];
   logic [63:0] mdl_key [SLOTS];
   logic [31:0] mdl_value [SLOTS];
   logic [3:0]  cur_key_bytes;
   logic [3:0]  cur_bucket_bits;

   rsp_item_type pending_rsp[$];
   int           mismatches = 0;
   bit           hold_off = 1'b0;
   bit           sender_done = 1'b0;
   logic [63:0]  recent_keys[$];

   hashed_key_value_table u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] key_hash(logic [63:0] key, int k);
      logic [31:0] h;
      h = '0;
      if (k == 1 || k == 2 || k == 4) begin
         h = 32'(key & ((64'd1 << (8 * k)) - 64'd1));
      end else if (k == 8) begin
         h = key[31:0] + key[63:32];
      end else begin
         for (int i = k; i > 0; i--) begin
            h = {h[27:0], h[31:28]} + 32'(key[8*(i-1) +: 8]);
         end
      end
      return h;
   endfunction

   function automatic rsp_item_type table_apply(req_item_type r);
      rsp_item_type o;
      int k, bucket, base, hit, freew;
      logic [63:0] km;
      logic [31:0] bmask;
      o = '0;
      k = (cur_key_bytes > 8) ? 8 : int'(cur_key_bytes);
      km = (k >= 8) ? '1 : (64'd1 << (8 * k)) - 64'd1;
      bmask = (32'd1 << cur_bucket_bits) - 32'd1;
      bucket = int'((key_hash(r.key, k) & bmask) % BUCKETS);
      base = bucket * WAYS;
      hit = -1;
      freew = -1;
      for (int w = 0; w < WAYS; w++) begin
         if (mdl_valid[base + w]) begin
            if (hit < 0 && ((mdl_key[base + w] ^ r.key) & km) == '0) hit = w;
         end else if (freew < 0) begin
            freew = w;
         end
      end
      if (r.req_type != REQ_NONE && hit >= 0) o.found = 1'b1;
      case (r.req_type)
         REQ_MATCH: begin
            if (hit >= 0) o.value_out = mdl_value[base + hit];
         end
         REQ_ENTER: begin
            if (hit >= 0) begin
               mdl_value[base + hit] = r.value;
            end else if (freew >= 0) begin
               mdl_valid[base + freew] = 1'b1;
               mdl_key[base + freew] = r.key;
               mdl_value[base + freew] = r.value;
            end else begin
               o.status = 1'b1;
            end
         end
         REQ_REMOVE: begin
            if (hit >= 0) mdl_valid[base + hit] = 1'b0;
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic send_request(req_item_type r, int gap);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_checked(req_item_type r, int gap);
      pending_rsp.push_back(table_apply(r));
      send_request(r, gap);
   endtask

   task automatic drain_all();
      req_push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [3:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_KEY_BYTES) cur_key_bytes = data;
      else cur_bucket_bits = data;
      @(posedge clock);
   endtask

   function automatic logic [63:0] random_key();
      logic [63:0] key;
      key = {$urandom, $urandom};
      if (recent_keys.size() != 0 && $urandom_range(0, 99) < 60) begin
         key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
         if ($urandom_range(0, 3) == 0) key[63:32] = $urandom;
      end else if ($urandom_range(0, 3) == 0) begin
         key = 64'($urandom_range(0, 31));
      end
      return key;
   endfunction

   task automatic random_phase(int count, bit quick);
      req_item_type r;
      int p;
      for (int n = 0; n < count; n++) begin
         p = $urandom_range(0, 99);
         r.req_type = (p < 40) ? REQ_ENTER : (p < 70) ? REQ_MATCH :
                      (p < 95) ? REQ_REMOVE : REQ_NONE;
         r.key = random_key();
         r.value = $urandom;
         if (recent_keys.size() < 40) recent_keys.push_back(r.key);
         else recent_keys[$urandom_range(0, 39)] = r.key;
         send_checked(r, quick ? 0 : ($urandom_range(0, 3) == 0 ?
                      $urandom_range(0, 17) : 0));
      end
   endtask

   // receiver
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         wait_cycles = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
         if (wait_cycles != 0 || hold_off) begin
            rsp_pop <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_data);
         end else begin
            if (rsp_data.found !== pending_rsp[0].found ||
                rsp_data.value_out !== pending_rsp[0].value_out ||
                rsp_data.status !== pending_rsp[0].status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", pending_rsp[0], rsp_data);
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   // long receiver stall, counted in its own process
   initial begin
      @(negedge reset);
      wait (sender_done);
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      table_row_type rows[$];
      req_item_type r;
      rsp_item_type got;
      cur_key_bytes = KEY_BYTES_RESET;
      cur_bucket_bits = BUCKET_BITS_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         mdl_valid[i] = 1'b0;
         mdl_key[i] = '0;
         mdl_value[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // after reset: table empty, key size 4, all buckets in use
      rows.push_back('{REQ_MATCH, 64'h0, 32'h0, 1, '{1'b0, 32'h0, 1'b0}});
      rows.push_back('{REQ_ENTER, 64'h0, 32'hffff_ffff, 1, '{1'b0, 32'h0, 1'b0}});
      rows.push_back('{REQ_MATCH, 64'h0, 32'h0, 1, '{1'b1, 32'hffff_ffff, 1'b0}});
      rows.push_back('{REQ_ENTER, 64'h0, 32'h1234_5678, 1, '{1'b1, 32'h0, 1'b0}});
      rows.push_back('{REQ_MATCH, 64'hffff_ffff_0000_0000, 32'h0, 1,
                       '{1'b1, 32'h1234_5678, 1'b0}});
      rows.push_back('{REQ_NONE, 64'h0, 32'hffff_ffff, 1, '{1'b0, 32'h0, 1'b0}});
      rows.push_back('{REQ_REMOVE, 64'h0, 32'h0, 1, '{1'b1, 32'h0, 1'b0}});
      rows.push_back('{REQ_REMOVE, 64'h0, 32'h0, 1, '{1'b0, 32'h0, 1'b0}});
      rows.push_back('{REQ_ENTER, 64'hffff_ffff_ffff_ffff, 32'h1, 0, '0});
      rows.push_back('{REQ_MATCH, 64'hffff_ffff_ffff_ffff, 32'h0, 0, '0});
      // five keys into one bucket: 1024 apart
      for (int i = 0; i < 5; i++)
         rows.push_back('{REQ_ENTER, 64'(1 + 1024 * i), 32'(i + 7), i == 4,
                          '{1'b0, 32'h0, 1'b1}});
      foreach (rows[i]) begin
         r.req_type = rows[i].req_type;
         r.key = rows[i].key;
         r.value = rows[i].value;
         got = table_apply(r);
         pending_rsp.push_back(rows[i].has_rsp ? rows[i].rsp : got);
         send_request(r, $urandom_range(0, 17));
      end
      drain_all();

      // key size zero: every key maps to bucket 0 and the enter takes its first slot
      write_csr(CSR_KEY_BYTES, 4'd0);
      send_checked('{REQ_MATCH, 64'h55, 32'h0}, 0);
      send_checked('{REQ_ENTER, 64'haa, 32'h9}, 0);
      drain_all();
      // narrow key after wide entries: duplicates compare equal
      write_csr(CSR_KEY_BYTES, 4'd8);
      write_csr(CSR_BUCKET_BITS, 4'd0);
      send_checked('{REQ_ENTER, 64'h1_0000_0005, 32'h11}, 0);
      send_checked('{REQ_ENTER, 64'h2_0000_0005, 32'h22}, 0);
      drain_all();
      write_csr(CSR_KEY_BYTES, 4'd1);
      send_checked('{REQ_MATCH, 64'h5, 32'h0}, 0);
      send_checked('{REQ_REMOVE, 64'h5, 32'h0}, 0);
      send_checked('{REQ_MATCH, 64'h5, 32'h0}, 0);
      drain_all();
      write_csr(CSR_KEY_BYTES, 4'd15);
      write_csr(CSR_BUCKET_BITS, 4'd15);
      send_checked('{REQ_ENTER, 64'hdead_beef_0bad_f00d, 32'h3}, 0);
      send_checked('{REQ_MATCH, 64'hdead_beef_0bad_f00d, 32'h0}, 0);
      drain_all();

      // random phases under several settings
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_KEY_BYTES, ph == 0 ? 4'd1 : 4'($urandom_range(0, 15)));
         write_csr(CSR_BUCKET_BITS, ph == 1 ? 4'd0 : ph == 2 ? 4'd10 :
                   4'($urandom_range(0, 15)));
         recent_keys.delete();
         random_phase(ph == 7 ? 400 : 95, 1'b0);
         drain_all();
      end
      // sender keeps pushing while the receiver holds off
      sender_done = 1'b1;
      random_phase(60, 1'b1);
      drain_all();
      if (mismatches == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/hkv_pkg.sv
rtl/hkv_ram.sv
rtl/hkv_queue.sv
rtl/hkv_front.sv
rtl/hkv_back.sv
rtl/hashed_key_value_table.sv
rtl/hkv_checker.sv
tb/tb_hashed_key_value_table.sv
